// ----- rtl/lpus_pkg.sv -----
// Shared types, widths and codes of the longitude path unwrap and shift block.
package lpus_pkg;

  // Field widths
  localparam int IN_W     = 32;
  localparam int LAT_W    = 32;
  localparam int LON_W    = 40;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 8;

  // Reduction unit: signed operand width, working width, offset exponent
  localparam int DIV_X_W      = LON_W + 1;
  localparam int DIV_W        = LON_W + 2;
  localparam int DIV_OFF_EXP  = 32;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RIGHT = 1'b1;
  localparam logic [IN_W-1:0] WINDOW_LEFT_RST  = 32'hFF4C_0000;
  localparam logic [IN_W-1:0] WINDOW_RIGHT_RST = 32'h00B4_0000;

  // Parameter defaults
  localparam int MAX_VERTICES_DEF = 64;
  localparam int FRAC_BITS_DEF    = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // Input transaction
  typedef struct packed {
    logic signed [IN_W-1:0]  lon_in;
    logic signed [LAT_W-1:0] lat_in;
    logic [KIND_W-1:0]       vertex_kind;
    logic                    last_vertex;
    logic                    pole_check;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic signed [LON_W-1:0] lon_out;
    logic signed [LAT_W-1:0] lat_out;
    logic [KIND_W-1:0]       kind_out;
    logic [COUNT_W-1:0]      copy_count;
    logic                    run_end;
  } res_item_t;

  // One buffered vertex
  typedef struct packed {
    logic [LON_W-1:0]  lon;
    logic [LAT_W-1:0]  lat;
    logic [KIND_W-1:0] kind;
  } store_t;

  // Operand select of the reduction unit
  typedef enum logic [1:0] {
    SEL_LON = 2'd0,
    SEL_A   = 2'd1,
    SEL_H   = 2'd2
  } div_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     div_go;
    div_sel_e div_sel;
    logic     commit;
    logic     cap_a;
    logic     finish;
    logic     rd_en;
  } lpus_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic last;
    logic div_done;
    logic rd_last;
    logic pipe_busy;
  } lpus_sts_t;

endpackage

// ----- rtl/lpus_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lpus_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lpus_div.sv -----
// Floor division by one full turn by scaled reciprocal multiplication.
module lpus_div #(
  parameter int FracBits = lpus_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          go_i,
  input  logic [lpus_pkg::DIV_X_W-1:0]                  x_i,
  output logic                                          done_o,
  output logic [lpus_pkg::DIV_OFF_EXP-FracBits+1:0]     q_o,
  output logic [lpus_pkg::DIV_W-1:0]                    rem_o
);
  import lpus_pkg::*;

  // Quotient bits: offset exponent over the turn plus two headroom bits
  localparam int Nq    = DIV_OFF_EXP - FracBits + 2;
  // A full turn is 45 << Shift, so the operand above Shift is divided by 45
  localparam int Shift = FracBits + 3;
  // Operand above Shift stays below 2^31 for every allowed fraction width
  localparam int YhW   = 31;
  localparam int PrW   = YhW + 32;
  localparam int RecSh = 37;
  // ceil(2^37 / 45): exact quotient for every operand below 2^31
  localparam logic [31:0] Recip = 32'd3054198967;
  // Offset of whole turns that makes any operand non-negative
  localparam logic [DIV_W-1:0] Offset = DIV_W'(360) << DIV_OFF_EXP;
  localparam logic [DIV_W-1:0] LoMask = (DIV_W'(1) << Shift) - DIV_W'(1);

  logic [DIV_W-1:0]     y_q, rem_q;
  logic [PrW-1:0]       prod_q;
  logic [Nq-1:0]        q_q;
  logic [1:0]           step_q;
  logic [YhW-1:0]       yh, q45, ym;
  logic [PrW-RecSh-1:0] qf;

  // Quotient from the product, remainder of the upper part by compare-free subtract
  always_comb begin
    yh  = YhW'(y_q >> Shift);
    qf  = prod_q[PrW-1:RecSh];
    q45 = {qf, 5'b0} + YhW'({qf, 3'b0}) + YhW'({qf, 2'b0}) + YhW'(qf);
    ym  = yh - q45;
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (go_i) begin
      step_q <= 2'd2;
    end else if (step_q != '0) begin
      step_q <= step_q - 2'd1;
    end
  end

  // Offset operand, reciprocal product, then quotient and remainder
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      y_q <= {x_i[DIV_X_W-1], x_i} + Offset;
    end
    if (step_q == 2'd2) begin
      prod_q <= PrW'(yh) * PrW'(Recip);
    end
    if (step_q == 2'd1) begin
      q_q   <= Nq'(qf);
      rem_q <= (DIV_W'(ym) << Shift) | (y_q & LoMask);
    end
  end

  assign done_o = (step_q == '0);
  assign q_o    = q_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/lpus_ctrl.sv -----
// Controller state machine: load, unwrap, window quotients and drain sequencing.
module lpus_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output lpus_pkg::lpus_cmd_t cmd_o,
  input  lpus_pkg::lpus_sts_t sts_i
);
  import lpus_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_CHECK    = 8'b0000_0010,
    ST_WAIT_LON = 8'b0000_0100,
    ST_GO_A     = 8'b0000_1000,
    ST_WAIT_A   = 8'b0001_0000,
    ST_WAIT_H   = 8'b0010_0000,
    ST_DRAIN    = 8'b0100_0000,
    ST_FLUSH    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = SEL_LON;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts_i.full) begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = SEL_LON;
          state_d       = ST_WAIT_LON;
        end else if (sts_i.last) begin
          state_d = ST_GO_A;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WAIT_LON: begin
        if (sts_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d      = sts_i.last ? ST_GO_A : ST_IDLE;
        end
      end
      ST_GO_A: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = SEL_A;
        state_d       = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (sts_i.div_done) begin
          cmd_o.cap_a   = 1'b1;
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = SEL_H;
          state_d       = ST_WAIT_H;
        end
      end
      ST_WAIT_H: begin
        if (sts_i.div_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.rd_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ----- rtl/lpus_dp.sv -----
// Datapath: window registers, unwrap arithmetic, path buffer and result stage.
module lpus_dp #(
  parameter int MaxVertices = lpus_pkg::MAX_VERTICES_DEF,
  parameter int FracBits    = lpus_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lpus_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lpus_pkg::IN_W-1:0]           cfg_data_i,
  input  lpus_pkg::in_item_t                  item_i,
  input  lpus_pkg::lpus_cmd_t                 cmd_i,
  output lpus_pkg::lpus_sts_t                 sts_o,
  output logic                                res_valid_o,
  output lpus_pkg::res_item_t                 res_o
);
  import lpus_pkg::*;

  localparam int AddrW = $clog2(MaxVertices);
  localparam int CntW  = $clog2(MaxVertices + 1);
  localparam int J0    = DIV_OFF_EXP - FracBits;
  localparam int Nq    = J0 + 2;
  localparam int SumW  = Nq + 1;
  // Residue of a longitude modulo one turn, and one sign bit more
  localparam int ResW  = FracBits + 9;
  localparam int ResW1 = ResW + 1;

  localparam logic [ResW:0]    FullR    = ResW1'(360) << FracBits;
  localparam logic [ResW:0]    HalfR    = ResW1'(180) << FracBits;
  localparam logic [ResW:0]    NegHalfR = ResW1'(0) - HalfR;
  localparam logic [DIV_X_W-1:0] HalfLon = DIV_X_W'(180) << FracBits;
  localparam logic [IN_W:0]    PoleLimit =
      (IN_W + 1)'(((64'd899 << FracBits) + 64'd9) / 64'd10);
  localparam logic [SumW-1:0]  CntBias  = SumW'(1) << (J0 + 1);

  // Registers
  logic [IN_W-1:0]    win_left_q, win_right_q;
  in_item_t           item_q;
  logic [CntW-1:0]    total_q;
  logic [LON_W-1:0]   prev_q, first_q, least_q, greatest_q;
  logic [ResW-1:0]    resid_q;
  logic [Nq-1:0]      qa_q;
  logic [LON_W-1:0]   adj_q;
  logic [COUNT_W-1:0] count_q;
  logic [CntW-1:0]    rd_idx_q;
  logic               rv1_q, rlast1_q;
  logic               res_valid_q;
  res_item_t          res_q;

  // Combinational
  logic [DIV_X_W-1:0] lon_x, a_x, h_x, div_x, adj_x;
  logic [LON_W-1:0]   lon40, u_step, u;
  logic [ResW-1:0]    lr;
  logic [ResW:0]      e, w;
  logic [IN_W:0]      lat_x, alat;
  logic [DIV_X_W-1:0] span, aspan;
  logic               reject, rd_last;
  logic [SumW-1:0]    sum, diff;
  logic [COUNT_W-1:0] cnt;
  logic               div_done;
  logic [Nq-1:0]      div_q;
  logic [DIV_W-1:0]   div_rem;
  store_t             wr_ent, rd_ent;
  logic [$bits(store_t)-1:0] ram_rdata;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q  <= WINDOW_LEFT_RST;
      win_right_q <= WINDOW_RIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LEFT:  win_left_q  <= cfg_data_i;
        REG_WINDOW_RIGHT: win_right_q <= cfg_data_i;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Operands of the reduction unit
  always_comb begin
    lon_x = {{(DIV_X_W-IN_W){item_q.lon_in[IN_W-1]}}, item_q.lon_in};
    a_x   = {{(DIV_X_W-IN_W){win_right_q[IN_W-1]}}, win_right_q}
          - {{(DIV_X_W-LON_W){least_q[LON_W-1]}}, least_q};
    h_x   = {{(DIV_X_W-LON_W){greatest_q[LON_W-1]}}, greatest_q}
          - {{(DIV_X_W-IN_W){win_left_q[IN_W-1]}}, win_left_q};
    case (cmd_i.div_sel)
      SEL_LON: div_x = lon_x;
      SEL_A:   div_x = a_x;
      SEL_H:   div_x = h_x;
      default: div_x = lon_x;
    endcase
  end

  lpus_div #(
    .FracBits (FracBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.div_go),
    .x_i    (div_x),
    .done_o (div_done),
    .q_o    (div_q),
    .rem_o  (div_rem)
  );

  // Unwrap: step from the previous residue, folded into a half turn each way
  always_comb begin
    lon40 = {{(LON_W-IN_W){item_q.lon_in[IN_W-1]}}, item_q.lon_in};
    lr    = div_rem[ResW-1:0];
    e     = {1'b0, lr} - {1'b0, resid_q};
    if ($signed(e) >= $signed(HalfR)) begin
      w = e - FullR;
    end else if ($signed(e) < $signed(NegHalfR)) begin
      w = e + FullR;
    end else begin
      w = e;
    end
    u_step = prev_q + {{(LON_W-ResW-1){w[ResW]}}, w};
    lat_x  = {item_q.lat_in[IN_W-1], item_q.lat_in};
    alat   = lat_x[IN_W] ? ((IN_W + 1)'(0) - lat_x) : lat_x;
    if (total_q == '0 || alat >= PoleLimit) begin
      u = lon40;
    end else begin
      u = u_step;
    end
  end

  // Pole rejection and copy count
  always_comb begin
    span   = {prev_q[LON_W-1], prev_q} - {first_q[LON_W-1], first_q};
    aspan  = span[DIV_X_W-1] ? (DIV_X_W'(0) - span) : span;
    reject = item_q.pole_check && (aspan > HalfLon);
    sum    = {1'b0, qa_q} + {1'b0, div_q} + SumW'(1);
    diff   = sum - CntBias;
    if (sum < CntBias) begin
      cnt = '0;
    end else if (diff > SumW'(COUNT_MAX)) begin
      cnt = COUNT_MAX;
    end else begin
      cnt = diff[COUNT_W-1:0];
    end
    adj_x = a_x - div_rem[DIV_X_W-1:0];
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // Path state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      prev_q     <= '0;
      first_q    <= '0;
      least_q    <= '0;
      greatest_q <= '0;
    end else begin
      if (cmd_i.commit) begin
        total_q <= total_q + CntW'(1);
        prev_q  <= u;
        if (total_q == '0) begin
          first_q    <= u;
          least_q    <= u;
          greatest_q <= u;
        end else begin
          if ($signed(u) < $signed(least_q)) begin
            least_q <= u;
          end
          if ($signed(u) > $signed(greatest_q)) begin
            greatest_q <= u;
          end
        end
      end else if (cmd_i.rd_en && rd_last) begin
        total_q <= '0;
      end
    end
  end

  // Residue, shift and count
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      resid_q <= lr;
    end
    if (cmd_i.cap_a) begin
      qa_q  <= div_q;
      adj_q <= adj_x[LON_W-1:0];
    end
    if (cmd_i.finish) begin
      count_q <= reject ? '0 : cnt;
      if (reject) begin
        adj_q <= '0;
      end
    end
  end

  // Path buffer
  assign wr_ent.lon  = u;
  assign wr_ent.lat  = item_q.lat_in;
  assign wr_ent.kind = item_q.vertex_kind;

  lpus_ram #(
    .Width ($bits(store_t)),
    .Depth (MaxVertices)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (total_q[AddrW-1:0]),
    .wdata_i (wr_ent),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_ent  = ram_rdata;
  assign rd_last = (rd_idx_q == total_q - CntW'(1));

  // Drain read pointer and read pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      rv1_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_en) begin
        rd_idx_q <= rd_idx_q + CntW'(1);
      end
      rv1_q       <= cmd_i.rd_en;
      res_valid_q <= rv1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rlast1_q <= rd_last;
  end

  // Result register: apply the whole-turn shift
  always_ff @(posedge clk_i) begin
    if (rv1_q) begin
      res_q.lon_out    <= rd_ent.lon + adj_q;
      res_q.lat_out    <= rd_ent.lat;
      res_q.kind_out   <= rd_ent.kind;
      res_q.copy_count <= count_q;
      res_q.run_end    <= rlast1_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Status to controller
  assign sts_o.full      = (total_q == CntW'(MaxVertices));
  assign sts_o.last      = item_q.last_vertex;
  assign sts_o.div_done  = div_done;
  assign sts_o.rd_last   = rd_last;
  assign sts_o.pipe_busy = rv1_q | res_valid_q;

endmodule

// ----- rtl/longitude_path_unwrap_shift_core.sv -----
// Top level of the longitude path unwrap and whole-turn shift block.
//
// Vertices enter through a command port: a transaction is taken at a clock
// edge with start high and busy low. Each vertex is reduced modulo one turn
// in a reciprocal-multiply unit before it is stored; a vertex beyond the
// buffer depth is not stored.
// On the vertex marked last, two more reductions find the window quotients,
// then the buffered path is read from the path RAM one vertex per cycle.
// Results appear on res_o with res_valid_o high for one cycle each, back to
// back, each behind the RAM read register and the result register; run_end
// marks the final one. The receiver cannot stall results.
// busy stays high past the last result and falls once the read pipeline is empty.
// The user must write the window registers via cfg_valid_i/cfg_index_i/cfg_data_i
// only while the block is idle; it does not enforce this. cfg_ready_o is always high.
// Reset clears the path (empty), the tracked longitudes and restores the
// window to -180 .. +180 degrees. The path RAM needs no clearing.
module longitude_path_unwrap_shift_core #(
  parameter int MaxVertices = lpus_pkg::MAX_VERTICES_DEF,
  parameter int FracBits    = lpus_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  lpus_pkg::in_item_t             item_i,
  output logic                           res_valid_o,
  output lpus_pkg::res_item_t            res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lpus_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lpus_pkg::IN_W-1:0]      cfg_data_i
);
  import lpus_pkg::*;

  lpus_cmd_t cmd;
  lpus_sts_t sts;

  lpus_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  lpus_dp #(
    .MaxVertices (MaxVertices),
    .FracBits    (FracBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ----- rtl/lpus_chk.sv -----
// Port-level checker for the path unwrap block, bound to the top level.
module lpus_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                res_valid_o,
  input lpus_pkg::res_item_t res_o
);
  import lpus_pkg::*;

  // Results only show while a transaction is in progress
  a_res_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result strobe while idle");

  // No result right after a new transaction is taken
  a_no_res_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !res_valid_o)
    else $error("result right after accepting a vertex");

  // Drained vertices come back to back with one copy count until run end
  a_drain_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.run_end) |=>
      (res_valid_o && $stable(res_o.copy_count)))
    else $error("drain broken or copy count changed mid path");

  // The run end closes the drain
  a_run_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.run_end) |=> !res_valid_o)
    else $error("result after run end");

endmodule

bind longitude_path_unwrap_shift_core lpus_chk u_lpus_chk (.*);
